/* rtl/ilst_pkg.sv */
// ----------------------------------------------------------------------------
// ilst_pkg
// Types and codes shared by the indexed list core, its cells and channels.
// ----------------------------------------------------------------------------
package ilst_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_EJECT  = 3'd5,
        CMD_FILTER = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_INS = 2'd1,
        OP_DEL = 2'd2,
        OP_WR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] power;
        logic               stable;
        logic [15:0]        tag;
    } entry_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [3:0]         position;
        logic [15:0]        entry_id;
        logic signed [15:0] entry_power;
        logic               entry_stable;
        logic [15:0]        entry_tag;
        logic signed [15:0] min_power;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         out_position;
        logic [15:0]        out_id;
        logic signed [15:0] out_power;
        logic               out_stable;
        logic [15:0]        out_tag;
        logic [4:0]         list_count;
        logic               last;
    } rsp_t;

    // only the first matches of a scan get a result of their own
    localparam int unsigned MaxReported = 16;

endpackage

/* rtl/ilst_chan_if.sv */
// ----------------------------------------------------------------------------
// ilst_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ilst_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ilst_cell.sv */
// ----------------------------------------------------------------------------
// ilst_cell
// One list slot: holds an entry, takes the write data at its position, and takes from a neighbor on shift commands.
// ----------------------------------------------------------------------------
module ilst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ilst_pkg::cell_op_t op,
    input  logic [CW-1:0]     pos,
    input  logic [CW-1:0]     len,
    input  ilst_pkg::entry_t  wdata,
    input  ilst_pkg::entry_t  left,
    input  ilst_pkg::entry_t  right,
    output ilst_pkg::entry_t  q
);
    import ilst_pkg::*;

    localparam logic [CW-1:0] MyIdx   = CW'(IDX);
    localparam logic [CW-1:0] NextIdx = CW'(IDX + 1);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            OP_INS:
            begin
                if (MyIdx == pos)
                begin
                    data_next = wdata;
                end
                else if (MyIdx > pos && MyIdx <= len)
                begin
                    data_next = left;
                end
            end
            OP_DEL:
            begin
                if (MyIdx >= pos && NextIdx < len)
                begin
                    data_next = right;
                end
            end
            OP_WR:
            begin
                if (MyIdx == pos)
                begin
                    data_next = wdata;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

/* rtl/indexed_list_insert_delete_search_core.sv */
// Insert, delete, write, read and clear register the command, then load one result
// into the output register once it is free. Find, eject and filter walk the cells one per
// cycle, pausing while a reported match waits for a free output. One command is taken at a
// time; the next is taken once the previous has issued its final result.
// Reset clears every cell, the length and the output register at once.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search_core
// Ordered list held in a row of cells with shift insert/delete, write, read, clear and scans.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_core #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ilst_chan_if.sink   req,
    ilst_chan_if.source rsp
);
    import ilst_pkg::*;

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (IW > 4) ? IW : 4;
    localparam int CW = (PW > LW) ? PW : LW;
    localparam int NW = (LW > 5) ? LW : 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] p_reg, p_next;
    logic [NW-1:0] n_reg, n_next;

    cell_op_t      cell_op;
    logic [CW-1:0] cell_pos;
    entry_t        wdata;
    entry_t        cells_q [LIST_DEPTH];
    entry_t        rd;
    logic [IW-1:0] rd_idx;

    logic [CW-1:0] pos_c, len_c, p_c, depth_c;
    logic          out_free;
    logic          load;
    rsp_t          item;

    assign pos_c   = CW'(req_reg.position);
    assign len_c   = CW'(len_reg);
    assign p_c     = CW'(p_reg);
    assign depth_c = CW'(LIST_DEPTH);

    assign wdata.id     = req_reg.entry_id;
    assign wdata.power  = req_reg.entry_power;
    assign wdata.stable = req_reg.entry_stable;
    assign wdata.tag    = req_reg.entry_tag;

    assign rd_idx   = (state_reg == S_SCAN) ? p_reg[IW-1:0] : pos_c[IW-1:0];
    assign rd       = cells_q[rd_idx];
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            entry_t left_d, right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cells_q[g-1];
            end
            if (g == LIST_DEPTH - 1)
            begin : g_tail
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cells_q[g+1];
            end
            ilst_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .op    (cell_op),
                .pos   (cell_pos),
                .len   (len_c),
                .wdata (wdata),
                .left  (left_d),
                .right (right_d),
                .q     (cells_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        len_next       = len_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        cell_op        = OP_NOP;
        cell_pos       = pos_c;
        load           = 1'b0;
        item           = '0;
        item.status    = ST_OK;
        item.last      = 1'b1;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next = req.data;
                    p_next   = '0;
                    n_next   = '0;
                    if (req.data.cmd == CMD_FIND || req.data.cmd == CMD_EJECT ||
                        req.data.cmd == CMD_FILTER)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load              = 1'b1;
                    state_next        = S_IDLE;
                    item.out_position = req_reg.position;
                    item.out_id       = wdata.id;
                    item.out_power    = wdata.power;
                    item.out_stable   = wdata.stable;
                    item.out_tag      = wdata.tag;
                    priority case (req_reg.cmd)
                        CMD_INSERT:
                        begin
                            if (pos_c >= depth_c || len_c >= depth_c)
                            begin
                                item        = '0;
                                item.status = ST_REJECT;
                                item.last   = 1'b1;
                            end
                            else
                            begin
                                cell_op  = OP_INS;
                                len_next = (pos_c < len_c) ? LW'(len_c + 1'b1)
                                                           : LW'(pos_c + 1'b1);
                            end
                        end
                        CMD_DELETE, CMD_READ:
                        begin
                            if (pos_c >= len_c)
                            begin
                                item        = '0;
                                item.status = ST_REJECT;
                                item.last   = 1'b1;
                            end
                            else
                            begin
                                item.out_id     = rd.id;
                                item.out_power  = rd.power;
                                item.out_stable = rd.stable;
                                item.out_tag    = rd.tag;
                                if (req_reg.cmd == CMD_DELETE)
                                begin
                                    cell_op  = OP_DEL;
                                    len_next = len_reg - 1'b1;
                                end
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (pos_c >= depth_c)
                            begin
                                item        = '0;
                                item.status = ST_REJECT;
                                item.last   = 1'b1;
                            end
                            else
                            begin
                                cell_op = OP_WR;
                                if (pos_c >= len_c)
                                begin
                                    len_next = LW'(pos_c + 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            // clear keeps the cell contents
                            item        = '0;
                            item.status = ST_OK;
                            item.last   = 1'b1;
                            len_next    = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (p_c >= len_c)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                        if (req_reg.cmd == CMD_FIND)
                        begin
                            item.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            item.out_position = n_reg[3:0];
                        end
                    end
                end
                else
                begin
                    item.out_id     = rd.id;
                    item.out_power  = rd.power;
                    item.out_stable = rd.stable;
                    item.out_tag    = rd.tag;
                    priority case (req_reg.cmd)
                        CMD_FIND:
                        begin
                            if (rd.id == req_reg.entry_id)
                            begin
                                if (out_free)
                                begin
                                    load              = 1'b1;
                                    state_next        = S_IDLE;
                                    item.out_position = p_c[3:0];
                                end
                            end
                            else
                            begin
                                p_next = p_reg + 1'b1;
                            end
                        end
                        CMD_FILTER:
                        begin
                            if (rd.power >= req_reg.min_power)
                            begin
                                if (n_reg >= NW'(MaxReported) || out_free)
                                begin
                                    load              = (n_reg < NW'(MaxReported));
                                    item.out_position = n_reg[3:0];
                                    item.last         = 1'b0;
                                    n_next            = n_reg + 1'b1;
                                    p_next            = p_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                p_next = p_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // eject: close the gap, stay on the same slot
                            if (!rd.stable)
                            begin
                                if (n_reg >= NW'(MaxReported) || out_free)
                                begin
                                    load              = (n_reg < NW'(MaxReported));
                                    item.out_position = n_reg[3:0];
                                    item.last         = 1'b0;
                                    n_next            = n_reg + 1'b1;
                                    cell_op           = OP_DEL;
                                    cell_pos          = p_c;
                                    len_next          = len_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                p_next = p_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_next            = item;
            rsp_next.list_count = 5'(len_next);
            rsp_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            len_reg       <= '0;
            p_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            len_reg       <= len_next;
            p_reg         <= p_next;
            n_reg         <= n_next;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(LIST_DEPTH))
        else $error("list length beyond depth");

    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> p_reg <= len_reg)
        else $error("scan pointer past list length");

    a_partial_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |->
            (req_reg.cmd == CMD_EJECT || req_reg.cmd == CMD_FILTER))
        else $error("non-final result outside eject or filter");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled result overwritten");
`endif

endmodule
